// ----- rtl/dgbl_pkg.sv -----
// Shared constants and types for the declination grid bilinear lookup.
// No dependencies; imported by the top level.
package dgbl_pkg;

  // default grid geometry
  localparam int GRID_STEP_DEG_DEF = 10;
  localparam int LAT_ROWS_DEF      = 19;
  localparam int LON_COLS_DEF      = 37;
  localparam int MIN_LAT_DEG_DEF   = -90;
  localparam int MIN_LON_DEG_DEF   = -180;

  // coordinate units and limits (1e-7 degree)
  localparam longint UNITS_PER_DEG = 64'sd10000000;
  localparam longint LAT_LIMIT     = 64'sd900000000;
  localparam longint LON_LIMIT     = 64'sd1800000000;

  // fraction format and result saturation (centidegrees)
  localparam int     FRAC_BITS  = 16;
  localparam int     VAL_W      = 16;
  localparam longint DECL_LIMIT = 64'sd18000;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_t;

endpackage

// ----- rtl/dgbl_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dgbl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 703
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read, holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/declination_grid_bilinear_lookup_top.sv -----
// Declination grid with bilinear lookup: 11-stage pipeline, four RAM banks.
// Depends on dgbl_pkg and dgbl_ram.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | req_type, grid_row, grid_col, grid_value,
//           |           |                     | latitude, longitude
//   out_    | output    | out_valid/out_stall | declination, in_range
//
// One beat in per cycle while in_stall is low, one result out per beat.
// Each grid entry is stored in four identical banks so the four corner reads
// of a query happen in the same cycle; write beats update all four banks.
// Reset (rst_n, synchronous) clears only the stage valid bits; the grid is
// undefined until written and has no clearing pass.
// A stalled output holds its beat; empty stages keep filling behind it, and
// in_stall rises only once every stage holds a beat.
module declination_grid_bilinear_lookup_top
  import dgbl_pkg::*;
#(
  parameter int GRID_STEP_DEG = GRID_STEP_DEG_DEF,
  parameter int LAT_ROWS      = LAT_ROWS_DEF,
  parameter int LON_COLS      = LON_COLS_DEF,
  parameter int MIN_LAT_DEG   = MIN_LAT_DEG_DEF,
  parameter int MIN_LON_DEG   = MIN_LON_DEG_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [4:0]         in_grid_row,
  input  logic [5:0]         in_grid_col,
  input  logic signed [15:0] in_grid_value,
  input  logic signed [31:0] in_latitude,
  input  logic signed [31:0] in_longitude,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_declination,
  output logic               out_in_range
);

  localparam int     NS     = 11;
  localparam longint STEP   = longint'(GRID_STEP_DEG) * UNITS_PER_DEG;
  localparam int     RW     = $clog2(STEP + 1);
  localparam int     RMW    = RW + 1;
  localparam longint M_IDX  = (longint'(1) <<< 32) / STEP;
  localparam int     QW     = $clog2(M_IDX + 1) + 1;
  localparam int     PQW    = 32 + QW;
  localparam longint M_FRAC = (longint'(1) <<< (RW + FRAC_BITS)) / STEP;
  localparam int     FW     = FRAC_BITS + 1;
  localparam int     FMW    = FRAC_BITS + 2;
  localparam int     PFW    = RW + FMW;
  localparam int     PMW    = RW + FW;
  localparam int     RIW    = $clog2(LAT_ROWS);
  localparam int     CIW    = $clog2(LON_COLS);
  localparam int     IW     = (RIW > CIW) ? RIW : CIW;
  localparam int     DEPTH  = LAT_ROWS * LON_COLS;
  localparam int     AW     = $clog2(DEPTH);
  localparam longint LAT_BASE = -longint'(MIN_LAT_DEG) * UNITS_PER_DEG;
  localparam longint LON_BASE = -longint'(MIN_LON_DEG) * UNITS_PER_DEG;
  localparam longint LAT_HI   = longint'(LAT_ROWS - 1) * STEP;
  localparam longint LON_HI   = longint'(LON_COLS - 1) * STEP;
  localparam logic signed [53:0] ROUND_HALF = 54'sd2147483648;

  // ---------------------------------------------------------------------------
  // flow control: a stage loads when it is empty or the next one loads
  logic [NS:1] vld_r, vld_nxt, en;

  always_comb begin
    en[NS] = !vld_r[NS] || !out_stall;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[1] = en[1] ? in_valid : vld_r[1];
    for (int k = 2; k <= NS; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = vld_r[NS];

  // ---------------------------------------------------------------------------
  // stage 1: offsets from grid origin, range checks, write address
  logic signed [33:0] c_ext [2];
  logic signed [33:0] c_off [2];
  logic [1:0]         c_ok, s1_hi_nxt;
  logic [31:0]        s1_off_nxt [2];
  logic               s1_ok_nxt, s1_wr_nxt;
  logic [AW-1:0]      s1_waddr_nxt;

  always_comb begin
    c_ext[0] = 34'(in_latitude);
    c_ext[1] = 34'(in_longitude);
    c_off[0] = c_ext[0] + 34'(LAT_BASE);
    c_off[1] = c_ext[1] + 34'(LON_BASE);
    c_ok[0]  = (longint'(c_ext[0]) >= -LAT_LIMIT) && (longint'(c_ext[0]) <= LAT_LIMIT);
    c_ok[1]  = (longint'(c_ext[1]) >= -LON_LIMIT) && (longint'(c_ext[1]) <= LON_LIMIT);
    s1_hi_nxt[0] = longint'(c_off[0]) >= LAT_HI;
    s1_hi_nxt[1] = longint'(c_off[1]) >= LON_HI;
    for (int k = 0; k < 2; k++) begin
      s1_off_nxt[k] = (c_off[k] > 34'sd0) ? c_off[k][31:0] : '0;
    end
    s1_ok_nxt    = (req_type_t'(in_req_type) == REQ_QUERY) && c_ok[0] && c_ok[1];
    s1_wr_nxt    = (req_type_t'(in_req_type) == REQ_WRITE) &&
                   (32'(in_grid_row) < 32'(LAT_ROWS)) && (32'(in_grid_col) < 32'(LON_COLS));
    s1_waddr_nxt = AW'(32'(in_grid_row) * 32'(LON_COLS) + 32'(in_grid_col));
  end

  logic [31:0]          s1_off_r [2];
  logic [1:0]           s1_hi_r;
  logic                 s1_ok_r, s1_wr_r;
  logic [AW-1:0]        s1_waddr_r;
  logic [VAL_W-1:0]     s1_wval_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_off_r   <= s1_off_nxt;
      s1_hi_r    <= s1_hi_nxt;
      s1_ok_r    <= s1_ok_nxt;
      s1_wr_r    <= s1_wr_nxt;
      s1_waddr_r <= s1_waddr_nxt;
      s1_wval_r  <= in_grid_value;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: cell index estimate by reciprocal multiply
  logic [PQW-1:0] q_prod [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      q_prod[k] = PQW'(s1_off_r[k]) * PQW'(M_IDX);
    end
  end

  logic [QW-1:0]    s2_q_r [2];
  logic [31:0]      s2_off_r [2];
  logic [1:0]       s2_hi_r;
  logic             s2_ok_r, s2_wr_r;
  logic [AW-1:0]    s2_waddr_r;
  logic [VAL_W-1:0] s2_wval_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 2; k++) begin
        s2_q_r[k] <= q_prod[k][32 +: QW];
      end
      s2_off_r   <= s1_off_r;
      s2_hi_r    <= s1_hi_r;
      s2_ok_r    <= s1_ok_r;
      s2_wr_r    <= s1_wr_r;
      s2_waddr_r <= s1_waddr_r;
      s2_wval_r  <= s1_wval_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: remainder of the estimate, below twice the step
  logic [32:0] q_step [2];
  logic [32:0] rem_raw [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      q_step[k]  = 33'(s2_q_r[k]) * 33'(STEP);
      rem_raw[k] = {1'b0, s2_off_r[k]} - q_step[k];
    end
  end

  logic [QW-1:0]    s3_q_r [2];
  logic [RMW-1:0]   s3_rem_r [2];
  logic [1:0]       s3_hi_r;
  logic             s3_ok_r, s3_wr_r;
  logic [AW-1:0]    s3_waddr_r;
  logic [VAL_W-1:0] s3_wval_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 2; k++) begin
        s3_rem_r[k] <= rem_raw[k][RMW-1:0];
      end
      s3_q_r     <= s2_q_r;
      s3_hi_r    <= s2_hi_r;
      s3_ok_r    <= s2_ok_r;
      s3_wr_r    <= s2_wr_r;
      s3_waddr_r <= s2_waddr_r;
      s3_wval_r  <= s2_wval_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: one correction step, then clamp to the last cell at the upper edge
  logic [1:0]     rem_cy;
  logic [QW-1:0]  q_fix [2];
  logic [IW-1:0]  s4_idx_nxt [2];
  logic [RW-1:0]  s4_rem_nxt [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      rem_cy[k] = s3_rem_r[k] >= RMW'(STEP);
      q_fix[k]  = s3_q_r[k] + QW'(rem_cy[k]);
      if (s3_hi_r[k]) begin
        s4_idx_nxt[k] = (k == 0) ? IW'(LAT_ROWS - 2) : IW'(LON_COLS - 2);
        s4_rem_nxt[k] = RW'(STEP);
      end else begin
        s4_idx_nxt[k] = IW'(q_fix[k]);
        s4_rem_nxt[k] = rem_cy[k] ? RW'(s3_rem_r[k] - RMW'(STEP)) : RW'(s3_rem_r[k]);
      end
    end
  end

  logic [IW-1:0]    s4_idx_r [2];
  logic [RW-1:0]    s4_rem_r [2];
  logic             s4_ok_r, s4_wr_r;
  logic [AW-1:0]    s4_waddr_r;
  logic [VAL_W-1:0] s4_wval_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_idx_r   <= s4_idx_nxt;
      s4_rem_r   <= s4_rem_nxt;
      s4_ok_r    <= s3_ok_r;
      s4_wr_r    <= s3_wr_r;
      s4_waddr_r <= s3_waddr_r;
      s4_wval_r  <= s3_wval_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: fraction estimate by reciprocal multiply, cell base address
  logic [PFW-1:0] f_prod [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      f_prod[k] = PFW'(s4_rem_r[k]) * PFW'(M_FRAC);
    end
  end

  logic [FW-1:0]    s5_fe_r [2];
  logic [RW-1:0]    s5_rem_r [2];
  logic [AW-1:0]    s5_base_r;
  logic             s5_ok_r, s5_wr_r;
  logic [AW-1:0]    s5_waddr_r;
  logic [VAL_W-1:0] s5_wval_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int k = 0; k < 2; k++) begin
        s5_fe_r[k] <= f_prod[k][RW +: FW];
      end
      s5_rem_r   <= s4_rem_r;
      s5_base_r  <= AW'(32'(s4_idx_r[0]) * 32'(LON_COLS) + 32'(s4_idx_r[1]));
      s5_ok_r    <= s4_ok_r;
      s5_wr_r    <= s4_wr_r;
      s5_waddr_r <= s4_waddr_r;
      s5_wval_r  <= s4_wval_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: back-multiply the fraction estimate, corner addresses
  logic [PMW-1:0] f_step [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      f_step[k] = PMW'(s5_fe_r[k]) * PMW'(STEP);
    end
  end

  logic [PMW-1:0]   s6_fstep_r [2];
  logic [FW-1:0]    s6_fe_r [2];
  logic [RW-1:0]    s6_rem_r [2];
  logic [AW-1:0]    s6_addr_r [4];
  logic             s6_ok_r, s6_wr_r;
  logic [AW-1:0]    s6_waddr_r;
  logic [VAL_W-1:0] s6_wval_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_fstep_r   <= f_step;
      s6_fe_r      <= s5_fe_r;
      s6_rem_r     <= s5_rem_r;
      s6_addr_r[0] <= s5_base_r;
      s6_addr_r[1] <= s5_base_r + AW'(1);
      s6_addr_r[2] <= s5_base_r + AW'(LON_COLS);
      s6_addr_r[3] <= s5_base_r + AW'(LON_COLS + 1);
      s6_ok_r      <= s5_ok_r;
      s6_wr_r      <= s5_wr_r;
      s6_waddr_r   <= s5_waddr_r;
      s6_wval_r    <= s5_wval_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: fraction correction; corner reads and grid writes in this slot
  logic [VAL_W-1:0] ram_rd [4];
  logic             ram_we;

  assign ram_we = en[7] && vld_r[6] && s6_wr_r;

  // banks: south-west, south-east, north-west, north-east corner
  for (genvar g = 0; g < 4; g++) begin : g_bank
    dgbl_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
    ) u_bank (
      .clk     (clk),
      .wr_en   (ram_we),
      .wr_addr (s6_waddr_r),
      .wr_data (s6_wval_r),
      .rd_en   (en[7]),
      .rd_addr (s6_addr_r[g]),
      .rd_data (ram_rd[g])
    );
  end

  logic [PMW-1:0] f_res [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      f_res[k] = PMW'({s6_rem_r[k], {FRAC_BITS{1'b0}}}) - s6_fstep_r[k];
    end
  end

  logic [FW-1:0] s7_frac_r [2];
  logic          s7_ok_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int k = 0; k < 2; k++) begin
        s7_frac_r[k] <= (f_res[k] >= PMW'(STEP)) ? s6_fe_r[k] + FW'(1) : s6_fe_r[k];
      end
      s7_ok_r <= s6_ok_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 8: interpolate along longitude on both rows
  logic signed [VAL_W-1:0] crn_sw, crn_se, crn_nw, crn_ne;
  logic signed [FW:0]      fx_s;
  logic signed [16:0]      d_lo, d_hi;
  logic signed [34:0]      p_lo, p_hi;

  always_comb begin
    crn_sw = signed'(ram_rd[0]);
    crn_se = signed'(ram_rd[1]);
    crn_nw = signed'(ram_rd[2]);
    crn_ne = signed'(ram_rd[3]);
    fx_s   = {1'b0, s7_frac_r[1]};
    d_lo   = 17'(crn_se) - 17'(crn_sw);
    d_hi   = 17'(crn_ne) - 17'(crn_nw);
    p_lo   = 35'(fx_s) * 35'(d_lo);
    p_hi   = 35'(fx_s) * 35'(d_hi);
  end

  logic signed [34:0] s8_dmin_r, s8_dmax_r;
  logic [FW-1:0]      s8_fy_r;
  logic               s8_ok_r;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_dmin_r <= (35'(crn_sw) <<< FRAC_BITS) + p_lo;
      s8_dmax_r <= (35'(crn_nw) <<< FRAC_BITS) + p_hi;
      s8_fy_r   <= s7_frac_r[0];
      s8_ok_r   <= s7_ok_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 9: difference between the rows
  logic signed [35:0] s9_diff_r;
  logic signed [34:0] s9_dmin_r;
  logic [FW-1:0]      s9_fy_r;
  logic               s9_ok_r;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_diff_r <= 36'(s8_dmax_r) - 36'(s8_dmin_r);
      s9_dmin_r <= s8_dmin_r;
      s9_fy_r   <= s8_fy_r;
      s9_ok_r   <= s8_ok_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 10: interpolate along latitude, add rounding half
  logic signed [FW:0]  fy_s;
  logic signed [53:0]  v_nxt;

  always_comb begin
    fy_s  = {1'b0, s9_fy_r};
    v_nxt = (54'(s9_dmin_r) <<< FRAC_BITS) + 54'(fy_s) * 54'(s9_diff_r) + ROUND_HALF;
  end

  logic signed [53:0] s10_v_r;
  logic               s10_ok_r;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s10_v_r  <= v_nxt;
      s10_ok_r <= s9_ok_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 11: floor to centidegrees, saturate, output register
  logic signed [21:0]      q_rnd, q_sat;
  logic signed [VAL_W-1:0] decl_nxt;

  always_comb begin
    q_rnd = signed'(s10_v_r[53:32]);
    if (q_rnd > 22'(DECL_LIMIT)) begin
      q_sat = 22'(DECL_LIMIT);
    end else if (q_rnd < -22'(DECL_LIMIT)) begin
      q_sat = -22'(DECL_LIMIT);
    end else begin
      q_sat = q_rnd;
    end
    decl_nxt = s10_ok_r ? VAL_W'(q_sat) : '0;
  end

  logic signed [VAL_W-1:0] out_declination_r;
  logic                    out_in_range_r;

  always_ff @(posedge clk) begin
    if (en[NS]) begin
      out_declination_r <= decl_nxt;
      out_in_range_r    <= s10_ok_r;
    end
  end

  assign out_declination = out_declination_r;
  assign out_in_range    = out_in_range_r;

endmodule
